[rtl/core/apr_pkg.sv]
`default_nettype none

package apr_pkg;

    localparam int GUARD_BITS = 2;
    localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

    typedef enum logic [1:0] {
        PLANE_X,
        PLANE_Y,
        PLANE_Z,
        PLANE_NONE
    } t_plane;

    typedef enum logic [2:0] {
        MODE_X,
        MODE_Y,
        MODE_Z,
        MODE_XY,
        MODE_XZ,
        MODE_YZ
    } t_axis_mode;

    typedef enum logic [1:0] {
        CFG_AXIS_MODE,
        CFG_FIRST_ANGLE,
        CFG_SECOND_ANGLE
    } t_cfg_index;

    typedef struct packed {
        logic   valid;
        t_plane plane;
    } t_rot_ctrl;

    // arctangent of 2^-i as a binary angle, full turn 2^32
    function automatic logic [31:0] atan_entry(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/apr_cordic_stage.sv]
`default_nettype none

module apr_cordic_stage import apr_pkg::*; #(
    parameter int WORK_WIDTH = 37,
    parameter int STAGE      = 0
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic signed [WORK_WIDTH-1:0] i_a,
    input  wire logic signed [WORK_WIDTH-1:0] i_b,
    input  wire logic signed [31:0]           i_z,
    output logic signed [WORK_WIDTH-1:0]      o_a,
    output logic signed [WORK_WIDTH-1:0]      o_b,
    output logic signed [31:0]                o_z
);

    localparam logic signed [31:0] ATAN = signed'(atan_entry(STAGE));

    logic signed [WORK_WIDTH-1:0] r_a, n_a;
    logic signed [WORK_WIDTH-1:0] r_b, n_b;
    logic signed [31:0]           r_z, n_z;
    logic signed [WORK_WIDTH-1:0] w_da, w_db;

    assign w_da = i_b >>> STAGE;
    assign w_db = i_a >>> STAGE;

    always_comb begin
        if (!i_z[31]) begin
            n_a = i_a - w_da;
            n_b = i_b + w_db;
            n_z = i_z - ATAN;
        end else begin
            n_a = i_a + w_da;
            n_b = i_b - w_db;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_z <= n_z;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_z = r_z;

endmodule

`default_nettype wire

[rtl/core/apr_gain_round.sv]
`default_nettype none

module apr_gain_round import apr_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int WORK_WIDTH  = 37
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [WORK_WIDTH-1:0]  i_value,
    output logic signed [COORD_WIDTH-1:0]      o_value
);

    localparam int MAG_W = (WORK_WIDTH - 1 > 33) ? WORK_WIDTH - 1 : 33;
    localparam int HI_W  = MAG_W - 32;
    localparam int PHI_W = HI_W + 31;
    localparam int P_W   = HI_W + 33;
    localparam logic [62:0]  HALF_Q31 = 63'(1) << 30;
    localparam logic [P_W:0] RND      = (P_W + 1)'(1) << (GUARD_BITS - 1);

    // stage 1: magnitude and sign
    logic signed [WORK_WIDTH-1:0] w_abs;
    logic [MAG_W-1:0]             r_mag;
    logic                         r_neg1;
    // stage 2: partial products
    logic [62:0]                  r_plo;
    logic [PHI_W-1:0]             r_phi;
    logic                         r_neg2;
    // stage 3: scaled magnitude
    logic [P_W-1:0]               r_p;
    logic                         r_neg3;
    // stage 4: rounding and saturation
    logic [P_W:0]                 w_ext;
    logic [P_W:0]                 w_rnd;
    logic signed [P_W:0]          w_sh;
    logic [P_W-COORD_WIDTH+1:0]   w_upper;
    logic signed [COORD_WIDTH-1:0] n_out;
    logic signed [COORD_WIDTH-1:0] r_out;

    assign w_abs = i_value[WORK_WIDTH-1] ? -i_value : i_value;

    always_comb begin
        w_ext = {1'b0, r_p};
        if (r_neg3) begin
            w_rnd = ~w_ext + RND + (P_W + 1)'(1);
        end else begin
            w_rnd = w_ext + RND;
        end
        w_sh    = signed'(w_rnd) >>> GUARD_BITS;
        w_upper = w_sh[P_W:COORD_WIDTH-1];
        if ((&w_upper) || !(|w_upper)) begin
            n_out = w_sh[COORD_WIDTH-1:0];
        end else if (w_sh[P_W]) begin
            n_out = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            n_out = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag  <= MAG_W'(unsigned'(w_abs));
            r_neg1 <= i_value[WORK_WIDTH-1];
            r_plo  <= 63'(r_mag[31:0]) * 63'(GAIN_Q31);
            r_phi  <= PHI_W'(r_mag[MAG_W-1:32]) * PHI_W'(GAIN_Q31);
            r_neg2 <= r_neg1;
            r_p    <= P_W'({r_phi, 1'b0}) + P_W'((r_plo + HALF_Q31) >> 31);
            r_neg3 <= r_neg2;
            r_out  <= n_out;
        end
    end

    assign o_value = r_out;

endmodule

`default_nettype wire

[rtl/core/apr_plane_rotator.sv]
`default_nettype none

module apr_plane_rotator import apr_pkg::*; #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire t_rot_ctrl                     i_ctrl,
    input  wire logic [31:0]                   i_angle,
    input  wire logic signed [COORD_WIDTH-1:0] i_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_z,
    output logic                               o_valid,
    output logic signed [COORD_WIDTH-1:0]      o_x,
    output logic signed [COORD_WIDTH-1:0]      o_y,
    output logic signed [COORD_WIDTH-1:0]      o_z
);

    localparam int W   = COORD_WIDTH + GUARD_BITS + 3;
    localparam int LAT = CORDIC_STAGES + 5;
    localparam logic [31:0] ANGLE_KEEP = ~((32'd1 << (32 - ANGLE_WIDTH)) - 32'd1);

    logic [31:0]            w_t, w_t_plus, w_r;
    logic [1:0]             w_q;
    logic signed [COORD_WIDTH-1:0] w_sa, w_sb;
    logic signed [W-1:0]    w_a, w_b;
    logic signed [W-1:0]    n_a0, n_b0;
    logic signed [W-1:0]    r_a0, r_b0;
    logic signed [31:0]     r_z0;

    logic signed [W-1:0]    w_ca [0:CORDIC_STAGES];
    logic signed [W-1:0]    w_cb [0:CORDIC_STAGES];
    logic signed [31:0]     w_cz [0:CORDIC_STAGES];

    logic signed [COORD_WIDTH-1:0] w_fa, w_fb;

    logic signed [COORD_WIDTH-1:0] r_ox [0:LAT-1];
    logic signed [COORD_WIDTH-1:0] r_oy [0:LAT-1];
    logic signed [COORD_WIDTH-1:0] r_oz [0:LAT-1];
    t_plane                        r_plane [0:LAT-1];
    logic [LAT-1:0]                r_valid;

    // quarter turns exact, residual in [-1/8, 1/8) turn
    assign w_t      = i_angle & ANGLE_KEEP;
    assign w_t_plus = w_t + 32'h2000_0000;
    assign w_q      = w_t_plus[31:30];
    assign w_r      = w_t - {w_q, 30'd0};

    always_comb begin
        case (i_ctrl.plane)
            PLANE_X: begin
                w_sa = i_y;
                w_sb = i_z;
            end
            PLANE_Y: begin
                w_sa = i_z;
                w_sb = i_x;
            end
            default: begin
                w_sa = i_x;
                w_sb = i_y;
            end
        endcase
        w_a = {{(W-COORD_WIDTH-GUARD_BITS){w_sa[COORD_WIDTH-1]}}, w_sa, GUARD_BITS'(0)};
        w_b = {{(W-COORD_WIDTH-GUARD_BITS){w_sb[COORD_WIDTH-1]}}, w_sb, GUARD_BITS'(0)};
        case (w_q)
            2'd1: begin
                n_a0 = -w_b;
                n_b0 = w_a;
            end
            2'd2: begin
                n_a0 = -w_a;
                n_b0 = -w_b;
            end
            2'd3: begin
                n_a0 = w_b;
                n_b0 = -w_a;
            end
            default: begin
                n_a0 = w_a;
                n_b0 = w_b;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a0 <= n_a0;
            r_b0 <= n_b0;
            r_z0 <= signed'(w_r);
        end
    end

    assign w_ca[0] = r_a0;
    assign w_cb[0] = r_b0;
    assign w_cz[0] = r_z0;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        apr_cordic_stage #(
            .WORK_WIDTH (W),
            .STAGE      (g)
        ) u_stage (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (w_ca[g]),
            .i_b   (w_cb[g]),
            .i_z   (w_cz[g]),
            .o_a   (w_ca[g+1]),
            .o_b   (w_cb[g+1]),
            .o_z   (w_cz[g+1])
        );
    end

    apr_gain_round #(
        .COORD_WIDTH (COORD_WIDTH),
        .WORK_WIDTH  (W)
    ) u_gain_a (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_value (w_ca[CORDIC_STAGES]),
        .o_value (w_fa)
    );

    apr_gain_round #(
        .COORD_WIDTH (COORD_WIDTH),
        .WORK_WIDTH  (W)
    ) u_gain_b (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_value (w_cb[CORDIC_STAGES]),
        .o_value (w_fb)
    );

    // side line: original point and plane travel with the word
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ox[0]    <= i_x;
            r_oy[0]    <= i_y;
            r_oz[0]    <= i_z;
            r_plane[0] <= i_ctrl.plane;
            for (int k = 1; k < LAT; k++) begin
                r_ox[k]    <= r_ox[k-1];
                r_oy[k]    <= r_oy[k-1];
                r_oz[k]    <= r_oz[k-1];
                r_plane[k] <= r_plane[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[LAT-2:0], i_ctrl.valid};
        end
    end

    always_comb begin
        o_x = r_ox[LAT-1];
        o_y = r_oy[LAT-1];
        o_z = r_oz[LAT-1];
        case (r_plane[LAT-1])
            PLANE_X: begin
                o_y = w_fa;
                o_z = w_fb;
            end
            PLANE_Y: begin
                o_z = w_fa;
                o_x = w_fb;
            end
            PLANE_Z: begin
                o_x = w_fa;
                o_y = w_fb;
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_valid[LAT-1];

endmodule

`default_nettype wire

[rtl/core/axis_point_rotator_unit.sv]
// a word runs through the first rotator, the second rotator and the output register
// throughput: one word per cycle unless stalled (fully pipelined cordic and gain stages)
// the pipeline holds under back-pressure only when its last stage and the output
// register are both full
// reset (synchronous, active low) clears the configuration registers and all valid bits
`default_nettype none

module axis_point_rotator_unit import apr_pkg::*; #(
    parameter int COORD_WIDTH   = 32,
    parameter int ANGLE_WIDTH   = 32,
    parameter int CORDIC_STAGES = 24,
    localparam int TDATA_W      = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    // point_x, point_y, point_z
    input  wire logic [TDATA_W-1:0] i_s_axis_tdata,
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    // rotated_x, rotated_y, rotated_z
    output logic [TDATA_W-1:0]      o_m_axis_tdata,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);

    localparam int CW = COORD_WIDTH;

    logic [2:0]  r_axis_mode;
    logic [31:0] r_first_angle;
    logic [31:0] r_second_angle;

    t_plane    w_first_plane, w_second_plane;
    t_rot_ctrl w_first_ctrl, w_second_ctrl;
    logic      w_pipe_en;
    logic      w_mid_valid, w_last_valid;

    logic signed [CW-1:0] w_in_x, w_in_y, w_in_z;
    logic signed [CW-1:0] w_mid_x, w_mid_y, w_mid_z;
    logic signed [CW-1:0] w_end_x, w_end_y, w_end_z;

    logic                 r_out_valid;
    logic [3*CW-1:0]      r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_mode    <= '0;
            r_first_angle  <= '0;
            r_second_angle <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_AXIS_MODE:    r_axis_mode    <= i_cfg_data[2:0];
                CFG_FIRST_ANGLE:  r_first_angle  <= i_cfg_data;
                CFG_SECOND_ANGLE: r_second_angle <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (r_axis_mode)
            MODE_X: begin
                w_first_plane  = PLANE_X;
                w_second_plane = PLANE_NONE;
            end
            MODE_Y: begin
                w_first_plane  = PLANE_Y;
                w_second_plane = PLANE_NONE;
            end
            MODE_Z: begin
                w_first_plane  = PLANE_Z;
                w_second_plane = PLANE_NONE;
            end
            MODE_XY: begin
                w_first_plane  = PLANE_X;
                w_second_plane = PLANE_Y;
            end
            MODE_XZ: begin
                w_first_plane  = PLANE_X;
                w_second_plane = PLANE_Z;
            end
            MODE_YZ: begin
                w_first_plane  = PLANE_Y;
                w_second_plane = PLANE_Z;
            end
            default: begin
                w_first_plane  = PLANE_NONE;
                w_second_plane = PLANE_NONE;
            end
        endcase
    end

    // pipeline moves unless its last stage is blocked by a waiting word
    assign w_pipe_en       = !w_last_valid || !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_pipe_en;

    assign w_in_x = i_s_axis_tdata[CW-1:0];
    assign w_in_y = i_s_axis_tdata[2*CW-1:CW];
    assign w_in_z = i_s_axis_tdata[3*CW-1:2*CW];

    assign w_first_ctrl.valid  = i_s_axis_tvalid;
    assign w_first_ctrl.plane  = w_first_plane;
    assign w_second_ctrl.valid = w_mid_valid;
    assign w_second_ctrl.plane = w_second_plane;

    apr_plane_rotator #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_pipe_en),
        .i_ctrl  (w_first_ctrl),
        .i_angle (r_first_angle),
        .i_x     (w_in_x),
        .i_y     (w_in_y),
        .i_z     (w_in_z),
        .o_valid (w_mid_valid),
        .o_x     (w_mid_x),
        .o_y     (w_mid_y),
        .o_z     (w_mid_z)
    );

    apr_plane_rotator #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_pipe_en),
        .i_ctrl  (w_second_ctrl),
        .i_angle (r_second_angle),
        .i_x     (w_mid_x),
        .i_y     (w_mid_y),
        .i_z     (w_mid_z),
        .o_valid (w_last_valid),
        .o_x     (w_end_x),
        .o_y     (w_end_y),
        .o_z     (w_end_z)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_pipe_en && w_last_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pipe_en && w_last_valid) begin
            r_out_data <= {w_end_z, w_end_y, w_end_x};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_out_data);

    a_pass_both_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_first_plane == PLANE_NONE) |-> (w_second_plane == PLANE_NONE))
        else $error("second step active without a first step");

    a_reserved_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index != CFG_AXIS_MODE && i_cfg_index != CFG_FIRST_ANGLE
            && i_cfg_index != CFG_SECOND_ANGLE)
        |=> ($stable(r_axis_mode) && $stable(r_first_angle) && $stable(r_second_angle)))
        else $error("reserved register index changed configuration");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("output word present after reset");

    a_hold_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready && w_last_valid) |-> !o_s_axis_tready)
        else $error("input taken while the pipeline end is blocked");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> $stable(r_out_data))
        else $error("waiting word overwritten");

endmodule

`default_nettype wire
